// File: src/nvr_pkg.sv
`default_nettype none
package nvr_pkg;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [2:0] REG_DIR_X    = 3'd3;
   localparam logic [2:0] REG_DIR_Y    = 3'd4;
   localparam logic [2:0] REG_DIR_Z    = 3'd5;
   localparam logic [2:0] REG_THRESH   = 3'd6;

   localparam int unsigned MaxPoints = 1024;
   localparam int unsigned CntWidth  = $clog2(MaxPoints + 1);
   localparam int unsigned IdxWidth  = 10;

   // Datapath steps, in order.
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DOT   = 6'b000010,
      ST_ROUND = 6'b000100,
      ST_PROJ  = 6'b001000,
      ST_SQ    = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic dot;
      logic round;
      logic proj;
      logic square;
      logic finish;
      logic rsp_take;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;
      logic rsp_valid;
   } status_type;

endpackage
`default_nettype wire

// File: src/nearest_vertex_to_ray.sv
// Streams vertices and reports, on the vertex marked last, the first vertex
// strictly nearest to the configured ray line and strictly within the
// threshold. Each vertex is taken when the block is idle and then passes
// through the per-axis multiplier steps (dot product, rounding, projection,
// squaring, compare) before the next is taken. The result is held in an
// output register until transferred; a new vertex is not taken while a result waits stalled.
`default_nettype none
module nearest_vertex_to_ray (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_point_z,
   input  wire logic               req_last_point,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_found,
   output logic [9:0]              rsp_vertex_index,
   output logic [62:0]             rsp_distance_squared,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   nvr_pkg::cmd_type    cmd;
   nvr_pkg::status_type status;

   assign csr_ready = 1'b1;
   assign rsp_valid = status.rsp_valid;

   nvr_control u_control (
      .clock, .reset, .req_valid, .req_stall, .rsp_stall, .status, .cmd
   );

   nvr_datapath u_datapath (
      .clock, .reset, .cmd, .status,
      .point_x(req_point_x), .point_y(req_point_y), .point_z(req_point_z),
      .last_point(req_last_point),
      .csr_we(csr_valid), .csr_index, .csr_data,
      .found(rsp_found), .vertex_index(rsp_vertex_index),
      .distance_squared(rsp_distance_squared)
   );

endmodule
`default_nettype wire

// File: src/nvr_datapath.sv
`default_nettype none
module nvr_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire nvr_pkg::cmd_type    cmd,
   output nvr_pkg::status_type      status,
   input  wire logic signed [31:0]  point_x,
   input  wire logic signed [31:0]  point_y,
   input  wire logic signed [31:0]  point_z,
   input  wire logic                last_point,
   input  wire logic                csr_we,
   input  wire logic [2:0]          csr_index,
   input  wire logic [31:0]         csr_data,
   output logic                     found,
   output logic [9:0]               vertex_index,
   output logic [62:0]              distance_squared
);

   logic signed [31:0] org_ff [3];
   logic signed [15:0] dir_ff [3];
   logic [31:0]        thr_ff;
   logic signed [32:0] d_ff [3];
   logic signed [48:0] prod_ff [3];
   logic signed [50:0] dot16_ff;
   logic signed [66:0] proj_ff [3];
   logic [63:0]        sq_ff [3];
   logic               last_ff;
   logic [nvr_pkg::CntWidth-1:0] cnt_ff;
   logic [9:0]         best_idx_ff;
   logic [63:0]        best_ff;
   logic               have_ff;
   logic               rv_ff, rf_ff;
   logic [9:0]         ri_ff;
   logic [62:0]        rd_ff;

   logic signed [50:0] dot_sum;
   logic signed [50:0] dot_rnd;
   logic [65:0]        dist_sum;
   logic [63:0]        dist_total;
   logic [63:0]        thr2;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0; org_ff[1] <= '0; org_ff[2] <= '0;
         dir_ff[0] <= '0; dir_ff[1] <= '0; dir_ff[2] <= 16'sd16384;
         thr_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            nvr_pkg::REG_ORIGIN_X: org_ff[0] <= csr_data;
            nvr_pkg::REG_ORIGIN_Y: org_ff[1] <= csr_data;
            nvr_pkg::REG_ORIGIN_Z: org_ff[2] <= csr_data;
            nvr_pkg::REG_DIR_X:    dir_ff[0] <= csr_data[15:0];
            nvr_pkg::REG_DIR_Y:    dir_ff[1] <= csr_data[15:0];
            nvr_pkg::REG_DIR_Z:    dir_ff[2] <= csr_data[15:0];
            nvr_pkg::REG_THRESH:   thr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Sum and rounding of the dot product.
   assign dot_sum = 51'(prod_ff[0]) + 51'(prod_ff[1]) + 51'(prod_ff[2]);
   assign dot_rnd = (dot_sum + 51'sd8192) >>> 14;

   // Saturating sum of squares and threshold squared.
   assign dist_sum = 66'(sq_ff[0]) + 66'(sq_ff[1]) + 66'(sq_ff[2]);
   assign dist_total = (dist_sum[65:64] != 2'b00) ? '1 : dist_sum[63:0];
   assign thr2 = 64'(thr_ff) * 64'(thr_ff);

   // Per-item arithmetic, one multiplier per axis per step.
   always_ff @(posedge clock) begin
      logic signed [67:0] e;
      logic [67:0]        a;
      if (cmd.load) begin
         d_ff[0] <= 33'(point_x) - 33'(org_ff[0]);
         d_ff[1] <= 33'(point_y) - 33'(org_ff[1]);
         d_ff[2] <= 33'(point_z) - 33'(org_ff[2]);
         last_ff <= last_point;
      end
      for (int i = 0; i < 3; i++) begin
         if (cmd.dot) prod_ff[i] <= 49'(d_ff[i]) * 49'(dir_ff[i]);
         if (cmd.proj) proj_ff[i] <= (67'(dir_ff[i]) * 67'(dot16_ff) + 67'sd8192) >>> 14;
         if (cmd.square) begin
            // The error is formed at full width; any magnitude of 2^32 or more saturates.
            e = 68'(d_ff[i]) - 68'(proj_ff[i]);
            a = e[67] ? 68'(-e) : 68'(e);
            if (a[67:32] != '0)
               sq_ff[i] <= '1;
            else
               sq_ff[i] <= 64'(a[31:0]) * 64'(a[31:0]);
         end
      end
      if (cmd.round) dot16_ff <= dot_rnd;
   end

   // Search state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; best_idx_ff <= '0; best_ff <= '1; have_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         if (cmd.rsp_take) rv_ff <= 1'b0;
         if (cmd.finish) begin
            if (last_ff) begin
               rv_ff <= 1'b1;
               if (cnt_ff < nvr_pkg::CntWidth'(nvr_pkg::MaxPoints) && dist_total < thr2
                   && dist_total < best_ff) begin
                  rf_ff <= 1'b1;
                  ri_ff <= cnt_ff[9:0];
                  rd_ff <= dist_total[63] ? '1 : dist_total[62:0];
               end else begin
                  rf_ff <= have_ff;
                  ri_ff <= have_ff ? best_idx_ff : '0;
                  rd_ff <= !have_ff ? '0 : (best_ff[63] ? '1 : best_ff[62:0]);
               end
               cnt_ff <= '0; best_idx_ff <= '0; best_ff <= '1; have_ff <= 1'b0;
            end else if (cnt_ff < nvr_pkg::CntWidth'(nvr_pkg::MaxPoints)) begin
               if (dist_total < thr2 && dist_total < best_ff) begin
                  best_ff <= dist_total;
                  best_idx_ff <= cnt_ff[9:0];
                  have_ff <= 1'b1;
               end
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   assign status.last = last_ff;
   assign status.rsp_valid = rv_ff;
   assign found = rf_ff;
   assign vertex_index = ri_ff;
   assign distance_squared = rd_ff;

endmodule
`default_nettype wire

// File: src/nvr_control.sv
`default_nettype none
module nvr_control (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                rsp_stall,
   input  wire nvr_pkg::status_type status,
   output nvr_pkg::cmd_type         cmd
);

   nvr_pkg::state_type state_ff, state_in;

   // An item is only taken in the idle state and when no result could be blocked behind it.
   assign req_stall = !state_ff[0] || (status.rsp_valid && rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nvr_pkg::ST_IDLE:  if (req_valid && !req_stall) state_in = nvr_pkg::ST_DOT;
         nvr_pkg::ST_DOT:   state_in = nvr_pkg::ST_ROUND;
         nvr_pkg::ST_ROUND: state_in = nvr_pkg::ST_PROJ;
         nvr_pkg::ST_PROJ:  state_in = nvr_pkg::ST_SQ;
         nvr_pkg::ST_SQ:    state_in = nvr_pkg::ST_OUT;
         nvr_pkg::ST_OUT:   state_in = nvr_pkg::ST_IDLE;
         default:           state_in = nvr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nvr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands follow the state directly.
   always_comb begin
      cmd.load     = state_ff == nvr_pkg::ST_IDLE && req_valid && !req_stall;
      cmd.dot      = state_ff == nvr_pkg::ST_DOT;
      cmd.round    = state_ff == nvr_pkg::ST_ROUND;
      cmd.proj     = state_ff == nvr_pkg::ST_PROJ;
      cmd.square   = state_ff == nvr_pkg::ST_SQ;
      cmd.finish   = state_ff == nvr_pkg::ST_OUT;
      cmd.rsp_take = status.rsp_valid && !rsp_stall;
   end

endmodule
`default_nettype wire

// File: bench/testbench.sv
`default_nettype none
module testbench;

   localparam int unsigned CYCLE_LIMIT = 1500000;
   localparam int unsigned RANDOM_POINTS = 750;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic        found;
      logic [9:0]  index;
      logic [62:0] dist_sq;
   } pick_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        last;
      logic        typed;
      pick_type    pick;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic req_last_point = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_found;
   logic [9:0] rsp_vertex_index;
   logic [62:0] rsp_distance_squared;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // Shadow copy of the configuration and the search state.
   logic signed [31:0] ray_origin [3];
   logic signed [15:0] ray_dir [3];
   logic [31:0] pick_limit;
   int unsigned vertex_count;
   logic [9:0] nearest_index;
   logic [63:0] nearest_dist_sq;
   logic nearest_valid;

   pick_type pending_picks[$];
   logic row_typed = 1'b0;
   pick_type row_pick = '0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   logic quiet = 1'b0;
   logic long_hold = 1'b0;

   nearest_vertex_to_ray uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Squared perpendicular distance of a vertex from the current ray line.
   function automatic logic [63:0] ray_distance_sq(logic signed [31:0] px,
         logic signed [31:0] py, logic signed [31:0] pz);
      longint d [3];
      longint u [3];
      longint dot;
      longint dot16;
      longint e;
      logic [63:0] mag;
      logic [63:0] sq;
      logic [64:0] acc;
      d[0] = longint'(px) - longint'(ray_origin[0]);
      d[1] = longint'(py) - longint'(ray_origin[1]);
      d[2] = longint'(pz) - longint'(ray_origin[2]);
      dot = 0;
      for (int i = 0; i < 3; i++) begin
         u[i] = longint'(ray_dir[i]);
         dot += d[i] * u[i];
      end
      dot16 = (dot + 8192) >>> 14;
      acc = '0;
      for (int i = 0; i < 3; i++) begin
         e = d[i] - ((u[i] * dot16 + 8192) >>> 14);
         mag = (e < 0) ? 64'(-e) : 64'(e);
         sq = (mag >= 64'h1_0000_0000) ? '1 : mag * mag;
         acc = {1'b0, acc[63:0]} + {1'b0, sq};
         if (acc[64]) acc = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
      end
      return acc[63:0];
   endfunction

   // Track configuration and vertex transfers, and check each result transfer.
   always @(posedge clock) begin
      logic [63:0] dist_now;
      pick_type pick;
      pick_type want;
      if (reset) begin
         ray_origin = '{0, 0, 0};
         ray_dir = '{16'sd0, 16'sd0, 16'sd16384};
         pick_limit = '0;
         vertex_count = 0;
         nearest_index = '0;
         nearest_dist_sq = '1;
         nearest_valid = 1'b0;
      end else begin
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run did not finish in time", $time);
            $display("*** FAILED ***");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_picks.size() == 0) begin
               mismatches++;
               $display("%0t: result transfer with nothing expected", $time);
            end else begin
               want = pending_picks.pop_front();
               if (rsp_found !== want.found) begin
                  mismatches++;
                  $display("%0t: found expected %0d actual %0d", $time, want.found,
                     rsp_found);
               end
               if (rsp_vertex_index !== want.index) begin
                  mismatches++;
                  $display("%0t: vertex_index expected %0d actual %0d", $time,
                     want.index, rsp_vertex_index);
               end
               if (rsp_distance_squared !== want.dist_sq) begin
                  mismatches++;
                  $display("%0t: distance_squared expected %h actual %h", $time,
                     want.dist_sq, rsp_distance_squared);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               nvr_pkg::REG_ORIGIN_X: ray_origin[0] = csr_data;
               nvr_pkg::REG_ORIGIN_Y: ray_origin[1] = csr_data;
               nvr_pkg::REG_ORIGIN_Z: ray_origin[2] = csr_data;
               nvr_pkg::REG_DIR_X:    ray_dir[0] = csr_data[15:0];
               nvr_pkg::REG_DIR_Y:    ray_dir[1] = csr_data[15:0];
               nvr_pkg::REG_DIR_Z:    ray_dir[2] = csr_data[15:0];
               nvr_pkg::REG_THRESH:   pick_limit = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            dist_now = ray_distance_sq(req_point_x, req_point_y, req_point_z);
            if (vertex_count < nvr_pkg::MaxPoints) begin
               if (dist_now < 64'(pick_limit) * 64'(pick_limit)
                     && dist_now < nearest_dist_sq) begin
                  nearest_dist_sq = dist_now;
                  nearest_index = vertex_count[9:0];
                  nearest_valid = 1'b1;
               end
               vertex_count++;
            end
            if (req_last_point) begin
               if (nearest_valid) begin
                  pick.found = 1'b1;
                  pick.index = nearest_index;
                  pick.dist_sq = nearest_dist_sq[63] ? '1 : nearest_dist_sq[62:0];
               end else begin
                  pick = '0;
               end
               pending_picks = {pending_picks, (row_typed ? row_pick : pick)};
               vertex_count = 0;
               nearest_index = '0;
               nearest_dist_sq = '1;
               nearest_valid = 1'b0;
            end
         end
      end
   end

   // Result side stalls: mostly short, a few long, and one long hold-off on request.
   always @(negedge clock) begin
      int unsigned hold;
      int unsigned roll;
      if (hold > 0) begin
         hold--;
         rsp_stall = 1'b1;
      end else if (long_hold) begin
         long_hold = 1'b0;
         hold = 400;
         rsp_stall = 1'b1;
      end else if (quiet || reset) begin
         rsp_stall = 1'b0;
      end else begin
         roll = $urandom_range(0, 9);
         if (roll < 7) begin
            rsp_stall = 1'b0;
         end else begin
            hold = (roll == 9) ? $urandom_range(10, 40) : $urandom_range(0, 2);
            rsp_stall = 1'b1;
         end
      end
   end

   function automatic int unsigned idle_gap();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (quiet || roll < 5) return 0;
      if (roll < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // One vertex transfer; valid stays high into the next item when there is no gap.
   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
         logic last, logic typed, pick_type pick);
      int unsigned gap;
      gap = idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_point_x = x;
      req_point_y = y;
      req_point_z = z;
      req_last_point = last;
      row_typed = typed;
      row_pick = pick;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
         logic [31:0] dx, logic [31:0] dy, logic [31:0] dz, logic [31:0] limit);
      write_reg(nvr_pkg::REG_ORIGIN_X, ox);
      write_reg(nvr_pkg::REG_ORIGIN_Y, oy);
      write_reg(nvr_pkg::REG_ORIGIN_Z, oz);
      write_reg(nvr_pkg::REG_DIR_X, dx);
      write_reg(nvr_pkg::REG_DIR_Y, dy);
      write_reg(nvr_pkg::REG_DIR_Z, dz);
      write_reg(nvr_pkg::REG_THRESH, limit);
   endtask

   // Random component of a vertex: on the ray at t, displaced by a little noise.
   function automatic logic [31:0] near_coord(int axis, longint t, longint spread);
      longint c;
      c = longint'(ray_origin[axis]) + ((t * longint'(ray_dir[axis])) >>> 14)
         + longint'($urandom_range(0, 2 * spread)) - spread;
      return c[31:0];
   endfunction

   function automatic logic [31:0] random_dir();
      case ($urandom_range(0, 5))
         0: return 32'(16'sd16384);
         1: return 32'(-16'sd16384);
         2: return 32'd0;
         3: return 32'd11585;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] random_origin();
      if ($urandom_range(0, 3) == 0) return $urandom();
      return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
   endfunction

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      int unsigned sent;
      int unsigned list_len;
      longint t;
      longint spread;
      logic [31:0] limit;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset configuration: zero threshold, so nothing qualifies.
      send_vertex('0, '0, '0, 1'b1, 1'b1, '0);
      wait_idle();

      // Ray along +z through the origin, limit 1.0.
      write_ray('0, '0, '0, '0, '0, 32'd16384, 32'h0001_0000);
      rows = '{
         '{'0, '0, '0, 1'b1, 1'b1, '{1'b1, 10'd0, 63'd0}},
         '{32'h7FFF_FFFF, 32'h8000_0000, '0, 1'b0, 1'b0, '0},
         '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
         '{'0, 32'h0000_8000, '0, 1'b0, 1'b0, '0},
         '{'0, 32'h0000_8000, 32'd7, 1'b0, 1'b0, '0},
         '{32'h0000_4000, '0, 32'h8000_0000, 1'b1, 1'b1, '{1'b1, 10'd4, 63'h1000_0000}},
         '{32'h0001_0000, '0, '0, 1'b1, 1'b1, '0},
         '{'0, 32'h0000_8000, 32'h0005_0000, 1'b0, 1'b0, '0},
         '{'0, 32'h0000_8000, 32'h0009_0000, 1'b1, 1'b1, '{1'b1, 10'd0, 63'h4000_0000}}
      };
      foreach (rows[i]) begin
         row = rows[i];
         send_vertex(row.x, row.y, row.z, row.last, row.typed, row.pick);
      end
      wait_idle();

      // Largest limit with the origin at the far corner: the distance saturates.
      write_ray(32'h8000_0000, '0, '0, '0, '0, 32'd16384, 32'hFFFF_FFFF);
      send_vertex(32'h7FFF_FFFE, '0, '0, 1'b1, 1'b1,
         '{1'b1, 10'd0, 63'h7FFF_FFFF_FFFF_FFFF});
      wait_idle();

      // Oversized list: only the first MaxPoints vertices are eligible.
      write_ray('0, '0, '0, 32'h0000_2D41, 32'hFFFF_D2BF, '0, 32'h0002_0000);
      write_reg(REG_UNUSED, $urandom());
      for (int i = 0; i < nvr_pkg::MaxPoints + 8; i++)
         send_vertex((i == 5 || i > nvr_pkg::MaxPoints) ? '0 : 32'h7FFF_FFFF, '0, '0,
            i == nvr_pkg::MaxPoints + 7, 1'b0, '0);
      wait_idle();

      // Random phases with fresh ray settings between them.
      sent = 0;
      while (sent < RANDOM_POINTS) begin
         case ($urandom_range(0, 4))
            0: limit = $urandom();
            1: limit = '0;
            2: limit = '1;
            default: limit = $urandom_range(1, 32'h0004_0000);
         endcase
         write_ray(random_origin(), random_origin(), random_origin(), random_dir(),
            random_dir(), random_dir(), limit);
         if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom());
         quiet = ($urandom_range(0, 4) == 0);
         if (sent == 0) long_hold = 1'b1;
         spread = longint'(limit >> 1);
         for (int n = 0; n < 120 && sent < RANDOM_POINTS; n++) begin
            list_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
               : $urandom_range(1, 8);
            for (int k = 0; k < list_len; k++) begin
               t = longint'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
               if ($urandom_range(0, 9) < 7)
                  send_vertex(near_coord(0, t, spread), near_coord(1, t, spread),
                     near_coord(2, t, spread), k == list_len - 1, 1'b0, '0);
               else
                  send_vertex($urandom(), $urandom(), $urandom(),
                     k == list_len - 1, 1'b0, '0);
               sent++;
            end
         end
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire
